/* hw/rtl/afhs_pkg.sv */
// ----------------------------------------------------------------------------
// afhs_pkg
// shared widths, codes, reset values and types of the autofocus stepper block
// ----------------------------------------------------------------------------
package afhs_pkg;

  localparam int unsigned PosW     = 8;   // motor position width
  localparam int unsigned ConW     = 32;  // contrast width
  localparam int unsigned LimW     = 8;   // width of the limit registers
  localparam int unsigned ActW     = 2;
  localparam int unsigned StageW   = 3;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned PatW     = 8;
  localparam int unsigned NumPat   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // event codes
  localparam logic [ActW-1:0] ActAbort    = 2'd0;
  localparam logic [ActW-1:0] ActStart    = 2'd1;
  localparam logic [ActW-1:0] ActContrast = 2'd2;
  localparam logic [ActW-1:0] ActTick     = 2'd3;

  // focus stage codes
  localparam logic [StageW-1:0] StIdle  = 3'd0;
  localparam logic [StageW-1:0] StHome  = 3'd1;
  localparam logic [StageW-1:0] StSweep = 3'd2;
  localparam logic [StageW-1:0] StHold  = 3'd3;
  localparam logic [StageW-1:0] StTest  = 3'd4;

  // homing phase codes
  localparam logic [PhaseW-1:0] PhIdle     = 3'd0;
  localparam logic [PhaseW-1:0] PhStart    = 3'd1;
  localparam logic [PhaseW-1:0] PhWaitHigh = 3'd2;
  localparam logic [PhaseW-1:0] PhBackOff  = 3'd3;
  localparam logic [PhaseW-1:0] PhWaitLow  = 3'd4;
  localparam logic [PhaseW-1:0] PhFailed   = 3'd5;
  localparam logic [PhaseW-1:0] PhSuccess  = 3'd6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBottomLimit  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTopLimit     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBackOffSteps = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSweepEnd     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTestMode     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStepPatterns = 3'd5;

  // configuration reset values
  localparam logic [LimW-1:0] RstBottomLimit  = 8'd120;
  localparam logic [LimW-1:0] RstTopLimit     = 8'd120;
  localparam logic [LimW-1:0] RstBackOffSteps = 8'd10;
  localparam logic [LimW-1:0] RstSweepEnd     = 8'd60;
  localparam logic            RstTestMode     = 1'b1;
  localparam logic [NumPat*PatW-1:0] RstStepPatterns = {8'o333, 8'o332, 8'o322, 8'o323};

  typedef struct packed {
    logic [LimW-1:0]        home_start_pos;
    logic [LimW-1:0]        seek_travel;
    logic [LimW-1:0]        back_off_steps;
    logic [LimW-1:0]        sweep_end;
    logic                   test_mode;
    logic [NumPat*PatW-1:0] step_patterns;
  } cfg_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [ConW-1:0] contrast;
    logic            home_switch;
  } item_t;

  typedef struct packed {
    logic              step_valid;
    logic [PatW-1:0]   step_pattern;
    logic              motor_enable;
    logic [PosW-1:0]   position;
    logic [PosW-1:0]   target;
    logic [StageW-1:0] stage;
    logic [PhaseW-1:0] home_phase;
    logic [PosW-1:0]   best_position;
  } res_t;

endpackage

/* hw/rtl/afhs_if.sv */
// ----------------------------------------------------------------------------
// afhs channel interfaces
// event input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface afhs_in_if;
  import afhs_pkg::*;
  logic            valid;
  logic            ready;
  logic [ActW-1:0] action;
  logic [ConW-1:0] contrast;
  logic            home_switch;
  modport source (output valid, action, contrast, home_switch, input ready);
  modport sink   (input valid, action, contrast, home_switch, output ready);
endinterface

interface afhs_out_if;
  import afhs_pkg::*;
  logic              valid;
  logic              ready;
  logic              step_valid;
  logic [PatW-1:0]   step_pattern;
  logic              motor_enable;
  logic [PosW-1:0]   position;
  logic [PosW-1:0]   target;
  logic [StageW-1:0] stage;
  logic [PhaseW-1:0] home_phase;
  logic [PosW-1:0]   best_position;
  modport source (output valid, step_valid, step_pattern, motor_enable, position, target,
                  stage, home_phase, best_position, input ready);
  modport sink   (input valid, step_valid, step_pattern, motor_enable, position, target,
                  stage, home_phase, best_position, output ready);
endinterface

interface afhs_cfg_if;
  import afhs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/afhs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// afhs_cfg_regs
// configuration register file, written through the config channel
// ----------------------------------------------------------------------------
module afhs_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  afhs_cfg_if.sink        cfg_i,
  output afhs_pkg::cfg_t  cfg_o
);
  import afhs_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgBottomLimit:  cfg_d.home_start_pos = cfg_i.data[LimW-1:0];
        CfgTopLimit:     cfg_d.seek_travel    = cfg_i.data[LimW-1:0];
        CfgBackOffSteps: cfg_d.back_off_steps = cfg_i.data[LimW-1:0];
        CfgSweepEnd:     cfg_d.sweep_end      = cfg_i.data[LimW-1:0];
        CfgTestMode:     cfg_d.test_mode      = cfg_i.data[0];
        CfgStepPatterns: cfg_d.step_patterns  = cfg_i.data[NumPat*PatW-1:0];
        default:         cfg_d = cfg_q;  // unknown index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.home_start_pos <= RstBottomLimit;
      cfg_q.seek_travel    <= RstTopLimit;
      cfg_q.back_off_steps <= RstBackOffSteps;
      cfg_q.sweep_end      <= RstSweepEnd;
      cfg_q.test_mode      <= RstTestMode;
      cfg_q.step_patterns  <= RstStepPatterns;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/afhs_engine.sv */
// ----------------------------------------------------------------------------
// afhs_engine
// focus state and the single-pass next-state logic for one event
// ----------------------------------------------------------------------------
module afhs_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  afhs_pkg::cfg_t  cfg_i,
  input  afhs_pkg::item_t item_i,
  input  logic            fire_i,
  output afhs_pkg::res_t  res_o
);
  import afhs_pkg::*;

  logic [StageW-1:0] stage_q, stage_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   tgt_q, tgt_d;
  logic [ConW-1:0]   latest_q, latest_d;
  logic [ConW-1:0]   peak_q, peak_d;
  logic [PosW-1:0]   best_q, best_d;
  logic              on_q, on_d;

  always_comb begin
    logic            step;
    logic [PatW-1:0] pat;
    logic            at;
    logic [ConW-1:0] diff;
    logic [ConW-1:0] margin;

    stage_d  = stage_q;
    phase_d  = phase_q;
    pos_d    = pos_q;
    tgt_d    = tgt_q;
    latest_d = latest_q;
    peak_d   = peak_q;
    best_d   = best_q;
    on_d     = on_q;
    step     = 1'b0;
    pat      = '0;
    at       = 1'b0;
    diff     = latest_q - peak_q;
    margin   = (peak_q >> 4) + ConW'(1);

    unique case (item_i.action)
      ActAbort: begin
        latest_d = '0;
        peak_d   = '0;
        stage_d  = StIdle;
        phase_d  = PhIdle;
        on_d     = 1'b0;
      end
      ActStart: begin
        if (stage_q != StHome) begin
          latest_d = '0;
          peak_d   = '0;
          pos_d    = '0;
          tgt_d    = '0;
          stage_d  = StHome;
          phase_d  = PhStart;
        end
      end
      ActContrast: begin
        if (stage_q != StHome) begin
          latest_d = item_i.contrast;
        end
      end
      default: begin  // frame tick
        // one step toward the target first
        if (pos_q != tgt_q) begin
          if (pos_q < tgt_q) begin
            pos_d = pos_q + PosW'(1);
          end else begin
            pos_d = pos_q - PosW'(1);
          end
          step = 1'b1;
          pat  = cfg_i.step_patterns[{pos_d[1:0], 3'b000} +: PatW];
        end
        at = (pos_d == tgt_q);

        unique case (stage_q)
          StHome: begin
            unique case (phase_q)
              PhStart: begin
                pos_d   = PosW'(cfg_i.home_start_pos);
                tgt_d   = '0;
                phase_d = PhWaitHigh;
                on_d    = 1'b1;
              end
              PhWaitHigh: begin
                if (item_i.home_switch) begin
                  phase_d = PhBackOff;
                  tgt_d   = '0;
                  pos_d   = PosW'(cfg_i.back_off_steps);
                end else if (at) begin
                  phase_d = PhFailed;
                end
              end
              PhBackOff: begin
                if (at) begin
                  pos_d   = '0;
                  tgt_d   = PosW'(cfg_i.seek_travel);
                  phase_d = PhWaitLow;
                end
              end
              PhWaitLow: begin
                if (!item_i.home_switch) begin
                  pos_d   = '0;
                  tgt_d   = '0;
                  phase_d = PhSuccess;
                end else if (at) begin
                  phase_d = PhFailed;
                end
              end
              default: ;
            endcase
            if (phase_d == PhFailed) begin
              if (cfg_i.test_mode) begin
                stage_d = StTest;
              end else begin
                stage_d = StIdle;
                on_d    = 1'b0;
              end
            end else if (phase_d == PhSuccess) begin
              stage_d = cfg_i.test_mode ? StTest : StSweep;
              tgt_d   = PosW'(cfg_i.sweep_end);
              best_d  = '0;
            end
          end
          StSweep: begin
            if (at) begin
              tgt_d   = best_q;
              stage_d = StHold;
            end else if (latest_q > peak_q && diff > margin) begin
              // new peak only when it beats the old one by more than 1/16 of it plus one
              peak_d = latest_q;
              best_d = pos_d;
            end
          end
          StTest: begin
            if (at) begin
              tgt_d = (tgt_q == '0) ? PosW'(cfg_i.sweep_end) : '0;
            end
          end
          default: ;
        endcase
      end
    endcase

    res_o.step_valid    = step;
    res_o.step_pattern  = pat;
    res_o.motor_enable  = on_d;
    res_o.position      = pos_d;
    res_o.target        = tgt_d;
    res_o.stage         = stage_d;
    res_o.home_phase    = phase_d;
    res_o.best_position = best_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= StIdle;
      phase_q  <= PhIdle;
      pos_q    <= '0;
      tgt_q    <= '0;
      latest_q <= '0;
      peak_q   <= '0;
      best_q   <= '0;
      on_q     <= 1'b0;
    end else if (fire_i) begin
      stage_q  <= stage_d;
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      tgt_q    <= tgt_d;
      latest_q <= latest_d;
      peak_q   <= peak_d;
      best_q   <= best_d;
      on_q     <= on_d;
    end
  end

endmodule

/* hw/rtl/autofocus_homing_stepper_controller.sv */
// ----------------------------------------------------------------------------
// autofocus_homing_stepper_controller
// contrast hill-climb autofocus with stepper homing and a test swing
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   -------  ---  ------------  -------------------------------------------
//   cfg_i    in   valid/ready   index, data (register write)
//   in_i     in   valid/ready   action, contrast, home_switch
//   out_o    out  valid/ready   step_valid, step_pattern, motor_enable,
//                               position, target, stage, home_phase,
//                               best_position
//
// one item per clock sustained while out_o is ready; an item goes from in_i to out_o
// through the input register, then the engine logic into the result register
// the state loop is one engine pass, so the next item sees the updated state
// reset (rst_ni low) puts config at its defaults and the focus state at idle
// a stall on out_o backs up one item in the input register, then drops ready
// config writes are always taken and apply to items processed afterward
//
module autofocus_homing_stepper_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  afhs_cfg_if.sink   cfg_i,
  afhs_in_if.sink    in_i,
  afhs_out_if.source out_o
);
  import afhs_pkg::*;

  cfg_t  cfg;
  item_t in_item_q;
  logic  in_valid_q;
  res_t  eng_res;
  res_t  out_res_q;
  logic  out_valid_q;
  logic  fire;
  logic  in_take;

  // configuration registers
  afhs_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // the engine runs when the item in the input register can move into the
  // result register: it is empty or being drained this cycle
  assign fire    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_take = in_i.valid && in_i.ready;

  // the input register frees itself in the same cycle it fires
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.action      <= in_i.action;
      in_item_q.contrast    <= in_i.contrast;
      in_item_q.home_switch <= in_i.home_switch;
    end
  end

  // focus state and next-state logic
  afhs_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (in_item_q),
    .fire_i (fire),
    .res_o  (eng_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= eng_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.step_valid    = out_res_q.step_valid;
  assign out_o.step_pattern  = out_res_q.step_pattern;
  assign out_o.motor_enable  = out_res_q.motor_enable;
  assign out_o.position      = out_res_q.position;
  assign out_o.target        = out_res_q.target;
  assign out_o.stage         = out_res_q.stage;
  assign out_o.home_phase    = out_res_q.home_phase;
  assign out_o.best_position = out_res_q.best_position;

`ifndef ASSERT_OFF
  // a processed item always lands in the result register
  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("engine fired but no result was registered");

  // no step means no coil pattern
  a_no_step_no_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.step_valid) |-> (out_o.step_pattern == '0))
    else $error("coil pattern driven without a step");

  // sweeping and holding are only reached through a successful homing run
  a_focus_after_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.stage == StSweep || out_o.stage == StHold))
      |-> (out_o.home_phase == PhSuccess))
    else $error("focus stage without successful homing");

  // test swing follows a finished homing run only
  a_test_after_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.stage == StTest)
      |-> (out_o.home_phase == PhSuccess || out_o.home_phase == PhFailed))
    else $error("test swing without finished homing");
`endif

endmodule
